// ===== rtl/rfr_pkg.sv =====
// Shared types, constants and the CRC step for the response frame receiver.
package rfr_pkg;

  // Frame constants.
  localparam logic [7:0]  HdrSync      = 8'hFF;
  localparam logic [7:0]  HdrMark      = 8'hFE;
  localparam logic [7:0]  InstrRead    = 8'h03;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [2:0]  LenPos       = 3'd7;
  localparam logic [7:0]  MinLen       = 8'd3;
  localparam logic [7:0]  GapMax       = 8'hFF;
  localparam logic [9:0]  ElapsedMax   = 10'h3FF;

  typedef enum logic [1:0] {
    FN_ARM  = 2'd0,
    FN_BYTE = 2'd1,
    FN_TICK = 2'd2,
    FN_NONE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_HEADER   = 4'd1,
    ST_ID       = 4'd2,
    ST_INSTR    = 4'd3,
    ST_ADDR     = 4'd4,
    ST_SHORT    = 4'd5,
    ST_CRC      = 4'd6,
    ST_TIMEOUT  = 4'd7,
    ST_TOO_LONG = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    REG_DEVICE_ID   = 2'd0,
    REG_EXP_ADDR    = 2'd1,
    REG_GAP_LIMIT   = 2'd2,
    REG_TOTAL_LIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_DRAIN = 2'b10
  } back_state_e;

  typedef struct packed {
    logic [7:0] device_id;
    logic [7:0] expected_address;
    logic [7:0] inter_byte_limit_ms;
    logic [9:0] total_limit_ms;
  } cfg_t;

  // Command from the front part: either one status word or a payload drain.
  typedef struct packed {
    logic       drain;
    status_e    status;
    logic [7:0] count;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] value;
    logic       last;
  } res_t;

  // One byte through CRC-16/MODBUS, reflected form.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/response_frame_receiver.sv =====
// Top level of the response frame receiver: register port, front, back and payload store.
//
//  channel   | direction | handshake            | words
//  ----------+-----------+----------------------+-------------------------------------
//  input     | in        | push / full          | func_i, data_byte_i
//  result    | out       | pop / empty          | status_o, value_o, last_o
//  registers | in/out    | psel/penable/pready  | paddr, pwdata, prdata (4 x 32 bits)
//
// The front part takes one input word per cycle while full is low; every check, the CRC
// step and the payload store write finish in that cycle. The payload of a good frame is
// read back from the store into the result queue as results are popped, and full stays
// high until its last payload byte has been read from the store.
// Reset clears all control state at once; the payload RAM needs no clearing pass.
// A stalled result side only fills the two-entry result queue and then holds the drain.
module response_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input words.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  // Result words.
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status_o,
  output logic [7:0]  value_o,
  output logic        last_o
);
  import rfr_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  cfg_t             cfg_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_ready;
  logic             drain_pending;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  res_t             res;

  // The register port never waits; the word address picks one of four registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id           <= 8'd1;
      cfg_q.expected_address    <= 8'd0;
      cfg_q.inter_byte_limit_ms <= 8'd5;
      cfg_q.total_limit_ms      <= 10'd10;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEVICE_ID:   cfg_q.device_id           <= pwdata[7:0];
        REG_EXP_ADDR:    cfg_q.expected_address    <= pwdata[7:0];
        REG_GAP_LIMIT:   cfg_q.inter_byte_limit_ms <= pwdata[7:0];
        REG_TOTAL_LIMIT: cfg_q.total_limit_ms      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVICE_ID:   prdata = {24'd0, cfg_q.device_id};
      REG_EXP_ADDR:    prdata = {24'd0, cfg_q.expected_address};
      REG_GAP_LIMIT:   prdata = {24'd0, cfg_q.inter_byte_limit_ms};
      REG_TOTAL_LIMIT: prdata = {22'd0, cfg_q.total_limit_ms};
      default:         prdata = 32'd0;
    endcase
  end

  // Front part: frame tracking, header and length checks, CRC and payload capture.
  rfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AddrW       (AddrW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push_i          (push),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .full_o          (full),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready),
    .drain_pending_i (drain_pending),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata)
  );

  // Payload store, written by the front part and read back by the drain.
  rfr_ram #(
    .Width (8),
    .Depth (MAX_PAYLOAD),
    .AddrW (AddrW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back part: turns commands into result words.
  rfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AddrW       (AddrW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_ready_o     (cmd_ready),
    .drain_pending_o (drain_pending),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .empty_o         (empty),
    .pop_i           (pop),
    .res_o           (res)
  );

  assign status_o = 4'(res.status);
  assign value_o  = res.value;
  assign last_o   = res.last;

  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_pending |-> full)
    else $error("input accepted while the payload store is being drained");

  a_cmd_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> cmd_ready)
    else $error("command issued into a full command queue");

  a_status_has_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.status != ST_OK) |-> (res.last && res.value == 8'd0))
    else $error("status word with a value or without the last mark");

endmodule

// ===== rtl/rfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rfr_front.sv =====
// Front part: takes input words, tracks the frame, checks it and issues commands.
module rfr_front #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AddrW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfr_pkg::cfg_t     cfg_i,
  input  logic              push_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        data_byte_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output rfr_pkg::cmd_t     cmd_o,
  input  logic              cmd_ready_i,
  input  logic              drain_pending_i,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_waddr_o,
  output logic [7:0]        ram_wdata_o
);
  import rfr_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD + 2);

  logic        armed_q, armed_d;
  logic [2:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  val_cnt_q, val_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  gap_q, gap_d;
  logic [9:0]  elapsed_q, elapsed_d;
  logic        accept;
  logic [15:0] crc_next;
  logic [7:0]  gap_inc;
  logic [9:0]  elapsed_inc;
  logic        emit;
  cmd_t        cmd;

  // Hold off new words while the command queue is full or a payload drain still needs the store.
  assign full_o = !cmd_ready_i || drain_pending_i;
  assign accept = push_i && !full_o;

  assign crc_next    = crc_feed(crc_q, data_byte_i);
  assign gap_inc     = (gap_q == GapMax) ? gap_q : gap_q + 8'd1;
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 10'd1;

  always_comb begin
    armed_d     = armed_q;
    byte_cnt_d  = byte_cnt_q;
    frame_len_d = frame_len_q;
    val_cnt_d   = val_cnt_q;
    crc_d       = crc_q;
    gap_d       = gap_q;
    elapsed_d   = elapsed_q;
    emit        = 1'b0;
    cmd         = '{drain: 1'b0, status: ST_OK, count: 8'd0};
    ram_we_o    = 1'b0;

    if (accept) begin
      if (func_e'(func_i) == FN_ARM) begin
        armed_d     = 1'b1;
        byte_cnt_d  = 3'd0;
        frame_len_d = 8'd0;
        val_cnt_d   = 8'd0;
        crc_d       = CrcInit;
        gap_d       = 8'd0;
        elapsed_d   = 10'd0;
      end else if (armed_q) begin
        case (func_e'(func_i))
          FN_TICK: begin
            gap_d     = gap_inc;
            elapsed_d = elapsed_inc;
            if (gap_inc > cfg_i.inter_byte_limit_ms || elapsed_inc > cfg_i.total_limit_ms) begin
              emit       = 1'b1;
              cmd.status = ST_TIMEOUT;
            end
          end
          FN_BYTE: begin
            gap_d = 8'd0;
            crc_d = crc_next;
            if (byte_cnt_q < LenPos) begin
              byte_cnt_d = byte_cnt_q + 3'd1;
              case (byte_cnt_q)
                3'd0, 3'd1: begin
                  if (data_byte_i != HdrSync) begin
                    emit = 1'b1; cmd.status = ST_HEADER;
                  end
                end
                3'd2: begin
                  if (data_byte_i != HdrMark) begin
                    emit = 1'b1; cmd.status = ST_HEADER;
                  end
                end
                3'd3: begin
                  if (data_byte_i != cfg_i.device_id) begin
                    emit = 1'b1; cmd.status = ST_ID;
                  end
                end
                3'd4: begin
                  if (data_byte_i != InstrRead) begin
                    emit = 1'b1; cmd.status = ST_INSTR;
                  end
                end
                3'd5: begin
                  if (data_byte_i != cfg_i.expected_address) begin
                    emit = 1'b1; cmd.status = ST_ADDR;
                  end
                end
                default: begin
                  frame_len_d = data_byte_i;
                  if (data_byte_i < MinLen) begin
                    emit = 1'b1; cmd.status = ST_SHORT;
                  end else if ({1'b0, data_byte_i} > MaxLen) begin
                    emit = 1'b1; cmd.status = ST_TOO_LONG;
                  end
                end
              endcase
            end else begin
              // Payload bytes go to the store; the two CRC bytes only feed the CRC.
              ram_we_o  = ({1'b0, val_cnt_q} + 9'd2) < {1'b0, frame_len_q};
              val_cnt_d = val_cnt_q + 8'd1;
              if (val_cnt_d >= frame_len_q) begin
                emit = 1'b1;
                if (crc_next != 16'd0) begin
                  cmd.status = ST_CRC;
                end else begin
                  cmd.drain = 1'b1;
                  cmd.count = frame_len_q - 8'd2;
                end
              end
            end
          end
          default: ;
        endcase
        if (emit) begin
          armed_d = 1'b0;
        end
      end
    end
  end

  assign cmd_valid_o = emit;
  assign cmd_o       = cmd;
  assign ram_waddr_o = val_cnt_q[AddrW-1:0];
  assign ram_wdata_o = data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      byte_cnt_q  <= 3'd0;
      frame_len_q <= 8'd0;
      val_cnt_q   <= 8'd0;
      crc_q       <= CrcInit;
      gap_q       <= 8'd0;
      elapsed_q   <= 10'd0;
    end else begin
      armed_q     <= armed_d;
      byte_cnt_q  <= byte_cnt_d;
      frame_len_q <= frame_len_d;
      val_cnt_q   <= val_cnt_d;
      crc_q       <= crc_d;
      gap_q       <= gap_d;
      elapsed_q   <= elapsed_d;
    end
  end

  a_cmd_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |=> !armed_q)
    else $error("front stayed armed after issuing a command");

  a_write_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (armed_q && byte_cnt_q == LenPos && !drain_pending_i))
    else $error("payload write outside the payload phase");

  a_no_values_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_cnt_q < LenPos) |-> (val_cnt_q == 8'd0))
    else $error("value count moved during the header");

endmodule

// ===== rtl/rfr_back.sv =====
// Back part: command queue, payload drain sequencer and result queue.
module rfr_back #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AddrW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rfr_pkg::cmd_t     cmd_i,
  output logic              cmd_ready_o,
  output logic              drain_pending_o,
  output logic              ram_re_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              empty_o,
  input  logic              pop_i,
  output rfr_pkg::res_t     res_o
);
  import rfr_pkg::*;

  // Two-entry command queue.
  cmd_t        cq_q [2];
  logic [1:0]  cq_vld_q, cq_vld_d;
  logic        cq_wr_q, cq_rd_q;
  logic        cq_pop;
  cmd_t        cq_head;

  // Drain sequencer.
  back_state_e state_q, state_d;
  logic [7:0]  left_q, left_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic        rd_vld_q, rd_last_q, rd_last_d;

  // Two-entry result queue.
  res_t        oq_q [2];
  logic        oq_wr_q, oq_rd_q;
  logic [1:0]  oq_cnt_q;
  logic        oq_push, oq_pop;
  res_t        oq_in;
  logic        room;

  assign cmd_ready_o = !(&cq_vld_q);
  assign cq_head     = cq_q[cq_rd_q];
  assign drain_pending_o = (state_q == BK_DRAIN) || rd_vld_q
                           || (cq_vld_q[0] && cq_q[0].drain)
                           || (cq_vld_q[1] && cq_q[1].drain);

  assign oq_pop = pop_i && !empty_o;
  assign room   = ({1'b0, oq_cnt_q} + {2'b00, rd_vld_q}) < 3'd2;

  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    addr_d    = addr_q;
    rd_last_d = rd_last_q;
    cq_pop    = 1'b0;
    ram_re_o  = 1'b0;
    oq_push   = 1'b0;
    oq_in     = '{status: ST_OK, value: ram_rdata_i, last: rd_last_q};

    case (state_q)
      BK_IDLE: begin
        if (cq_vld_q[cq_rd_q] && !rd_vld_q) begin
          if (cq_head.drain) begin
            cq_pop  = 1'b1;
            left_d  = cq_head.count;
            addr_d  = '0;
            state_d = BK_DRAIN;
          end else if (oq_cnt_q < 2'd2) begin
            cq_pop  = 1'b1;
            oq_push = 1'b1;
            oq_in   = '{status: cq_head.status, value: 8'd0, last: 1'b1};
          end
        end
      end
      BK_DRAIN: begin
        if (room) begin
          ram_re_o  = 1'b1;
          rd_last_d = (left_q == 8'd1);
          left_d    = left_q - 8'd1;
          addr_d    = addr_q + 1'b1;
          if (left_q == 8'd1) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase

    if (rd_vld_q) begin
      oq_push = 1'b1;
    end
  end

  // Valid bits of the command queue: a push and a pop never touch the same entry.
  always_comb begin
    cq_vld_d = cq_vld_q;
    if (cmd_valid_i && cmd_ready_o) begin
      cq_vld_d[cq_wr_q] = 1'b1;
    end
    if (cq_pop) begin
      cq_vld_d[cq_rd_q] = 1'b0;
    end
  end

  assign ram_raddr_o = addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      cq_q[cq_wr_q] <= cmd_i;
    end
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_in;
    end
    left_q    <= left_d;
    addr_q    <= addr_d;
    rd_last_q <= rd_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_vld_q <= 2'b00;
      cq_wr_q  <= 1'b0;
      cq_rd_q  <= 1'b0;
      state_q  <= BK_IDLE;
      rd_vld_q <= 1'b0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      cq_vld_q <= cq_vld_d;
      if (cmd_valid_i && cmd_ready_o) begin
        cq_wr_q <= !cq_wr_q;
      end
      if (cq_pop) begin
        cq_rd_q <= !cq_rd_q;
      end
      state_q  <= state_d;
      rd_vld_q <= ram_re_o;
      if (oq_push) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  assign empty_o = (oq_cnt_q == 2'd0);
  assign res_o   = oq_q[oq_rd_q];

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= 2'd2)
    else $error("result queue overflow");

  a_read_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (oq_cnt_q <= 2'd1))
    else $error("payload read returned with no room in the result queue");

  a_drain_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRAIN) |-> (left_q != 8'd0))
    else $error("drain running with nothing left to read");

endmodule
